// ===== rtl/core/rrtp_pkg.sv =====
// Package with the shared types and codes of the round-robin task picker.
package rrtp_pkg;

  localparam int SLOT_W = 10;
  localparam int STAT_W = 3;
  localparam int ACT_W  = 3;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_YIELD = 1'b1;

  localparam logic [STAT_W-1:0] ST_FREE     = 3'd0;
  localparam logic [STAT_W-1:0] ST_DYING    = 3'd1;
  localparam logic [STAT_W-1:0] ST_RUNNABLE = 3'd2;
  localparam logic [STAT_W-1:0] ST_RUNNING  = 3'd3;

  localparam logic [ACT_W-1:0] ACT_WRITE  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_RUN    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_KEEP   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_HALT   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_NOLIVE = 3'd4;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [ACT_W-1:0]  action;
    logic [SLOT_W-1:0] chosen_slot;
  } res_t;

endpackage

// ===== rtl/core/rrtp_req_if.sv =====
// Request channel interface of the round-robin task picker.
interface rrtp_req_if
  import rrtp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [SLOT_W-1:0] slot_index;
  logic [STAT_W-1:0] new_status;

  modport source (output valid, req_type, slot_index, new_status, input ready);
  modport sink (input valid, req_type, slot_index, new_status, output ready);
endinterface

// ===== rtl/core/rrtp_res_if.sv =====
// Result channel interface of the round-robin task picker.
interface rrtp_res_if
  import rrtp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [SLOT_W-1:0] chosen_slot;

  modport source (output valid, action, chosen_slot, input ready);
  modport sink (input valid, action, chosen_slot, output ready);
endinterface

// ===== rtl/core/rrtp_status_mem.sv =====
// Slot status memory with one write port and one registered read port.
module rrtp_status_mem
  import rrtp_pkg::*;
#(
  parameter int NUM_SLOTS = 1024,
  parameter int AW = $clog2(NUM_SLOTS)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [STAT_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [STAT_W-1:0] rdata
);

  logic [STAT_W-1:0] mem [NUM_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/rrtp_ctrl.sv =====
// Sequencer that clears the table, applies writes and scans the table on a yield.
module rrtp_ctrl
  import rrtp_pkg::*;
#(
  parameter int NUM_SLOTS = 1024,
  parameter int AW = $clog2(NUM_SLOTS)
) (
  input  logic              clk,
  input  logic              rst,
  rrtp_req_if.sink          req,
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output logic [STAT_W-1:0] mem_wdata,
  output logic              mem_re,
  output logic [AW-1:0]     mem_raddr,
  input  logic [STAT_W-1:0] mem_rdata,
  output res_t              res,
  input  logic              res_ready
);

  localparam int CW   = ((AW > SLOT_W) ? AW : SLOT_W) + 1;
  localparam int CNTW = $clog2(NUM_SLOTS + 1);

  state_t            state;
  state_t            state_next;
  logic [AW-1:0]     pos;
  logic [CNTW-1:0]   cnt;
  logic              chk_valid;
  logic [AW-1:0]     chk_pos;
  logic              chk_last;
  logic              live;
  logic [AW-1:0]     cur_slot;
  logic              cur_valid;
  logic [ACT_W-1:0]  res_action;
  logic [SLOT_W-1:0] res_slot;

  logic          acc;
  logic          is_wr;
  logic          in_range;
  logic          issue;
  logic          hit;
  logic          is_live;
  logic          keep;
  logic [CW-1:0] idx_ext;

  function automatic logic [AW-1:0] step_pos(input logic [AW-1:0] p);
    return (p == AW'(NUM_SLOTS - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    idx_ext  = CW'(req.slot_index);
    in_range = idx_ext < CW'(NUM_SLOTS);
    is_wr    = req.req_type == REQ_WRITE;
    hit      = mem_rdata == ST_RUNNABLE;
    is_live  = mem_rdata == ST_DYING || mem_rdata == ST_RUNNABLE || mem_rdata == ST_RUNNING;
    keep     = cur_valid && mem_rdata == ST_RUNNING;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (pos == AW'(NUM_SLOTS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req.valid) begin
          state_next = is_wr ? S_RESULT : S_SCAN;
        end
      end
      S_SCAN: begin
        if (chk_valid && (hit || chk_last)) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req.ready       = state == S_IDLE;
    acc             = req.ready && req.valid;
    issue           = state == S_SCAN && cnt != CNTW'(NUM_SLOTS);
    mem_we          = state == S_CLEAR || (acc && is_wr && in_range);
    mem_waddr       = (state == S_CLEAR) ? pos : idx_ext[AW-1:0];
    mem_wdata       = (state == S_CLEAR) ? ST_FREE : req.new_status;
    mem_re          = issue;
    mem_raddr       = pos;
    res.valid       = state == S_RESULT;
    res.action      = res_action;
    res.chosen_slot = res_slot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      pos       <= '0;
      cnt       <= '0;
      chk_valid <= 1'b0;
      cur_valid <= 1'b0;
      cur_slot  <= '0;
    end else begin
      state     <= state_next;
      chk_valid <= issue && state_next == S_SCAN;
      if (state == S_CLEAR) begin
        pos <= step_pos(pos);
      end
      if (acc && !is_wr) begin
        pos  <= cur_valid ? step_pos(cur_slot) : '0;
        cnt  <= '0;
        live <= 1'b0;
      end
      if (acc && is_wr) begin
        res_action <= ACT_WRITE;
        res_slot   <= '0;
      end
      if (issue) begin
        pos      <= step_pos(pos);
        cnt      <= cnt + 1'b1;
        chk_pos  <= pos;
        chk_last <= cnt == CNTW'(NUM_SLOTS - 1);
      end
      if (state == S_SCAN && chk_valid) begin
        live <= live | is_live;
        if (hit) begin
          cur_slot   <= chk_pos;
          cur_valid  <= 1'b1;
          res_action <= ACT_RUN;
          res_slot   <= SLOT_W'(chk_pos);
        end else if (chk_last) begin
          if (keep) begin
            res_action <= ACT_KEEP;
            res_slot   <= SLOT_W'(cur_slot);
          end else begin
            res_action <= (live || is_live) ? ACT_HALT : ACT_NOLIVE;
            res_slot   <= '0;
            cur_valid  <= 1'b0;
            cur_slot   <= '0;
          end
        end
      end
    end
  end

endmodule

// ===== rtl/core/round_robin_task_picker.sv =====
// Top level of the round-robin task picker with its output register.
// A write item's result passes through the controller's result state and then the
// output register; a yield item first scans the status memory, one slot at a time.
// One item is in work at a time; the output register holds a finished item meanwhile.
// After reset a clearing pass sets every slot free, with ready low.
module round_robin_task_picker
  import rrtp_pkg::*;
#(
  parameter int NUM_SLOTS = 1024
) (
  input  logic     clk,
  input  logic     rst,
  rrtp_req_if.sink req,
  rrtp_res_if.source res
);

  localparam int AW = $clog2(NUM_SLOTS);

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [STAT_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [STAT_W-1:0] mem_rdata;
  res_t              ctrl_res;
  logic              res_ready;
  logic              out_valid;
  logic [ACT_W-1:0]  out_action;
  logic [SLOT_W-1:0] out_slot;

  rrtp_status_mem #(
    .NUM_SLOTS(NUM_SLOTS),
    .AW(AW)
  ) u_mem (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re(mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  rrtp_ctrl #(
    .NUM_SLOTS(NUM_SLOTS),
    .AW(AW)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .req(req),
    .mem_we(mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re(mem_re),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata),
    .res(ctrl_res),
    .res_ready(res_ready)
  );

  assign res_ready = !out_valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl_res.valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_res.valid && res_ready) begin
      out_action <= ctrl_res.action;
      out_slot   <= ctrl_res.chosen_slot;
    end
  end

  assign res.valid       = out_valid;
  assign res.action      = out_action;
  assign res.chosen_slot = out_slot;

endmodule

// ===== rtl/core/rrtp_checker.sv =====
// Port-level checks of the round-robin task picker and their binding.
module rrtp_checker
  import rrtp_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ACT_W-1:0]  action,
  input logic [SLOT_W-1:0] chosen_slot
);

  a_clear_after_reset: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("Input is ready right after reset.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("Two items were accepted in consecutive cycles.");

  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action == ACT_WRITE || action == ACT_HALT || action == ACT_NOLIVE)
    |-> chosen_slot == '0)
    else $error("A result without a chosen task carries a nonzero slot.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(action) && $stable(chosen_slot))
    else $error("A stalled result item changed.");

endmodule

bind round_robin_task_picker rrtp_checker u_rrtp_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(req.valid),
  .in_ready(req.ready),
  .out_valid(res.valid),
  .out_ready(res.ready),
  .action(res.action),
  .chosen_slot(res.chosen_slot)
);
